// ===== design/page_table_map_and_walk_macros.svh =====
// Assertion macros used by the page table walker checker.
// Include with the bare file name; no other dependencies.
`ifndef PAGE_TABLE_MAP_AND_WALK_MACROS_SVH
`define PAGE_TABLE_MAP_AND_WALK_MACROS_SVH

// same-cycle implication
`define PTW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ptw_pkg.sv =====
// Shared constants, codes and types of the page table map and walk block.
// No dependencies.
`default_nettype none

package ptw_pkg;

  localparam int unsigned MAX_TABLES = 64;
  localparam int unsigned ENTRIES    = 512;
  localparam int unsigned SLOT_W     = $clog2(ENTRIES);
  localparam int unsigned TBL_W      = $clog2(MAX_TABLES);
  localparam int unsigned ADDR_W     = TBL_W + SLOT_W;
  localparam int unsigned USED_W     = $clog2(MAX_TABLES + 1);

  localparam int unsigned PAGE_W     = 40;
  localparam int unsigned VA_W       = 48;
  localparam int unsigned VPN_W      = VA_W - 12;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned SMALL_W    = 12;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_DATA_W  = VA_W + PAGE_W + DATA_W;
  localparam int unsigned OUT_DATA_W = PAGE_W + DATA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_FLAGS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_VALUE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 2'd2;

  localparam logic REQ_MAP = 1'b0;

  localparam logic [DATA_W-1:0]  ROOT_FILL       = 64'h0000_0000_0000_0018;
  localparam logic [DATA_W-1:0]  FLAG_MASK       = 64'h8000_0000_0000_01FF;
  localparam logic [PAGE_W-1:0]  RST_TABLE_BASE  = '0;
  localparam logic [SMALL_W-1:0] RST_TABLE_FLAGS = 12'd27;
  localparam logic [SMALL_W-1:0] RST_EMPTY_VALUE = 12'd28;

  typedef struct packed {
    logic              sub;
    logic [PAGE_W-1:0] a;
    logic [PAGE_W-1:0] b;
    logic [USED_W-1:0] lim;
  } alu_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] res;
    logic              lt;
  } alu_rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== design/ptw_ram.sv =====
// Simple dual-port table memory: one write port, one registered read port.
// No dependencies.
`default_nettype none

module ptw_ram #(
  parameter int unsigned AW = 15,
  parameter int unsigned DW = 64
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/ptw_alu.sv =====
// Shared 40-bit add/subtract unit with a bound compare on the result.
// Depends on ptw_pkg.
`default_nettype none

module ptw_alu (
  input  wire ptw_pkg::alu_req_t req_i,
  output ptw_pkg::alu_rsp_t      rsp_o
);

  logic [ptw_pkg::PAGE_W-1:0] b_eff;
  logic [ptw_pkg::PAGE_W-1:0] res;

  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign res   = req_i.a + b_eff + ptw_pkg::PAGE_W'(req_i.sub);

  assign rsp_o.res = res;
  assign rsp_o.lt  = (res < ptw_pkg::PAGE_W'(req_i.lim));

endmodule

`default_nettype wire

// ===== design/ptw_ctrl.sv =====
// Walk sequencer: config registers, request/result registers, table allocation,
// undo log and root clearing pass. Depends on ptw_pkg; drives ptw_alu and ptw_ram.
`default_nettype none

module ptw_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ptw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ptw_pkg::PAGE_W-1:0]      cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            in_type_i,
  input  wire logic [ptw_pkg::VA_W-1:0]        in_va_i,
  input  wire logic [ptw_pkg::PAGE_W-1:0]      in_page_i,
  input  wire logic [ptw_pkg::DATA_W-1:0]      in_flags_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [ptw_pkg::STATUS_W-1:0]    out_status_o,
  output logic      [ptw_pkg::PAGE_W-1:0]      out_page_o,
  output logic      [ptw_pkg::DATA_W-1:0]      out_flags_o,
  output ptw_pkg::alu_req_t                    alu_req_o,
  input  wire ptw_pkg::alu_rsp_t               alu_rsp_i,
  output ptw_pkg::mem_req_t                    mem_req_o,
  input  wire logic [ptw_pkg::DATA_W-1:0]      mem_rdata_i
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EV   = 4'd3;
  localparam logic [3:0] S_FILL = 4'd4;
  localparam logic [3:0] S_LINK = 4'd5;
  localparam logic [3:0] S_LEAF = 4'd6;
  localparam logic [3:0] S_UNDO = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam logic [1:0] LVL_LAST_UPPER = 2'd2;
  localparam logic [1:0] LVL_LEAF       = 2'd3;

  function automatic logic [ptw_pkg::SLOT_W-1:0] slot_of(
    input logic [ptw_pkg::VPN_W-1:0] vpn,
    input logic [1:0]                lvl
  );
    logic [ptw_pkg::SLOT_W-1:0] s;
    unique case (lvl)
      2'd0: s = vpn[4*ptw_pkg::SLOT_W-1 -: ptw_pkg::SLOT_W];
      2'd1: s = vpn[3*ptw_pkg::SLOT_W-1 -: ptw_pkg::SLOT_W];
      2'd2: s = vpn[2*ptw_pkg::SLOT_W-1 -: ptw_pkg::SLOT_W];
      2'd3: s = vpn[ptw_pkg::SLOT_W-1:0];
    endcase
    return s;
  endfunction

  // config
  logic [ptw_pkg::PAGE_W-1:0]  base_q;
  logic [ptw_pkg::SMALL_W-1:0] tef_q;
  logic [ptw_pkg::SMALL_W-1:0] eev_q;

  // sequencer
  logic [3:0]                  state_q, state_d;
  logic [1:0]                  lvl_q, lvl_d;
  logic [ptw_pkg::TBL_W-1:0]   cur_q, cur_d;
  logic [ptw_pkg::TBL_W-1:0]   new_q, new_d;
  logic [ptw_pkg::USED_W-1:0]  used_q, used_d;
  logic [ptw_pkg::USED_W-1:0]  saved_q, saved_d;
  logic [1:0]                  nlog_q, nlog_d;
  logic [ptw_pkg::SLOT_W-1:0]  cnt_q, cnt_d;
  logic [ptw_pkg::ADDR_W-1:0]  link_addr_q, link_addr_d;

  // undo log of overwritten link entries
  logic [ptw_pkg::ADDR_W-1:0]  log_addr_q [3];
  logic [ptw_pkg::DATA_W-1:0]  log_data_q [3];
  logic                        log_we;
  logic [1:0]                  log_top;

  // request
  logic                        type_q;
  logic [ptw_pkg::VPN_W-1:0]   vpn_q;
  logic [ptw_pkg::PAGE_W-1:0]  page_q;
  logic [ptw_pkg::DATA_W-1:0]  flags_q;
  logic                        req_ld;

  // result and output register
  logic [ptw_pkg::STATUS_W-1:0] rst_q, rst_d;
  logic [ptw_pkg::PAGE_W-1:0]   rpg_q, rpg_d;
  logic [ptw_pkg::DATA_W-1:0]   rfl_q, rfl_d;
  logic                         ovalid_q, ovalid_d;
  logic                         out_ld;
  logic [ptw_pkg::STATUS_W-1:0] ostat_q;
  logic [ptw_pkg::PAGE_W-1:0]   opage_q;
  logic [ptw_pkg::DATA_W-1:0]   oflags_q;

  logic [ptw_pkg::ADDR_W-1:0]   cur_addr;
  logic [ptw_pkg::DATA_W-1:0]   e;

  assign cur_addr = {cur_q, slot_of(vpn_q, lvl_q)};
  assign e        = mem_rdata_i;
  assign log_top  = nlog_q - 2'd1;

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = ovalid_q;
  assign out_status_o = ostat_q;
  assign out_page_o   = opage_q;
  assign out_flags_o  = oflags_q;

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    cur_d       = cur_q;
    new_d       = new_q;
    used_d      = used_q;
    saved_d     = saved_q;
    nlog_d      = nlog_q;
    cnt_d       = cnt_q;
    link_addr_d = link_addr_q;
    rst_d       = rst_q;
    rpg_d       = rpg_q;
    rfl_d       = rfl_q;
    ovalid_d    = ovalid_q && !out_ready_i;
    out_ld      = 1'b0;
    req_ld      = 1'b0;
    log_we      = 1'b0;

    alu_req_o.sub = 1'b1;
    alu_req_o.a   = e[ptw_pkg::PAGE_W+11:12];
    alu_req_o.b   = base_q;
    alu_req_o.lim = used_q;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = cur_addr;
    mem_req_o.wdata = '0;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = cur_addr;

    unique case (state_q)
      S_CLR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = {ptw_pkg::TBL_W'(0), cnt_q};
        mem_req_o.wdata = ptw_pkg::ROOT_FILL;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_ld  = 1'b1;
          lvl_d   = '0;
          cur_d   = '0;
          nlog_d  = '0;
          saved_d = used_q;
          state_d = S_RD;
        end
      end
      S_RD: begin
        mem_req_o.re = 1'b1;
        state_d      = S_EV;
      end
      S_EV: begin
        rst_d = ptw_pkg::ST_UNMAPPED;
        rpg_d = '0;
        rfl_d = '0;
        if (lvl_q == LVL_LEAF) begin
          if (e[0]) begin
            rst_d = ptw_pkg::ST_OK;
            rpg_d = e[ptw_pkg::PAGE_W+11:12];
            rfl_d = e & ptw_pkg::FLAG_MASK;
          end
          state_d = S_DONE;
        end else if (e[0]) begin
          if (alu_rsp_i.lt) begin
            cur_d = alu_rsp_i.res[ptw_pkg::TBL_W-1:0];
            if (lvl_q == LVL_LAST_UPPER && type_q == ptw_pkg::REQ_MAP) begin
              state_d = S_LEAF;
            end else begin
              lvl_d   = lvl_q + 2'd1;
              state_d = S_RD;
            end
          end else if (type_q == ptw_pkg::REQ_MAP) begin
            state_d = S_UNDO;
          end else begin
            state_d = S_DONE;
          end
        end else if (type_q != ptw_pkg::REQ_MAP) begin
          state_d = S_DONE;
        end else if (used_q >= ptw_pkg::USED_W'(ptw_pkg::MAX_TABLES)) begin
          state_d = S_UNDO;
        end else begin
          new_d       = used_q[ptw_pkg::TBL_W-1:0];
          used_d      = used_q + 1'b1;
          log_we      = 1'b1;
          nlog_d      = nlog_q + 2'd1;
          link_addr_d = cur_addr;
          cnt_d       = '0;
          state_d     = S_FILL;
        end
      end
      S_FILL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = {new_q, cnt_q};
        mem_req_o.wdata = {{(ptw_pkg::DATA_W-ptw_pkg::SMALL_W){1'b0}}, eev_q};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        alu_req_o.sub   = 1'b0;
        alu_req_o.a     = base_q;
        alu_req_o.b     = ptw_pkg::PAGE_W'(new_q);
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = link_addr_q;
        mem_req_o.wdata = {12'b0, alu_rsp_i.res, 12'b0}
                        | {{(ptw_pkg::DATA_W-ptw_pkg::SMALL_W){1'b0}}, tef_q};
        cur_d = new_q;
        if (lvl_q == LVL_LAST_UPPER) begin
          state_d = S_LEAF;
        end else begin
          lvl_d   = lvl_q + 2'd1;
          state_d = S_RD;
        end
      end
      S_LEAF: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = {cur_q, slot_of(vpn_q, LVL_LEAF)};
        mem_req_o.wdata = {12'b0, page_q, 12'b0} | flags_q;
        rst_d   = ptw_pkg::ST_OK;
        rpg_d   = '0;
        rfl_d   = '0;
        state_d = S_DONE;
      end
      S_UNDO: begin
        if (nlog_q == 2'd0) begin
          used_d  = saved_q;
          rst_d   = ptw_pkg::ST_NOSPACE;
          rpg_d   = '0;
          rfl_d   = '0;
          state_d = S_DONE;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = log_addr_q[log_top];
          mem_req_o.wdata = log_data_q[log_top];
          nlog_d = log_top;
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          out_ld   = 1'b1;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      cnt_q    <= '0;
      used_q   <= ptw_pkg::USED_W'(1);
      ovalid_q <= 1'b0;
      base_q   <= ptw_pkg::RST_TABLE_BASE;
      tef_q    <= ptw_pkg::RST_TABLE_FLAGS;
      eev_q    <= ptw_pkg::RST_EMPTY_VALUE;
      lvl_q    <= '0;
      cur_q    <= '0;
      nlog_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      used_q   <= used_d;
      ovalid_q <= ovalid_d;
      lvl_q    <= lvl_d;
      cur_q    <= cur_d;
      nlog_q   <= nlog_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ptw_pkg::CFG_TABLE_BASE:  base_q <= cfg_data_i;
          ptw_pkg::CFG_TABLE_FLAGS: tef_q  <= cfg_data_i[ptw_pkg::SMALL_W-1:0];
          ptw_pkg::CFG_EMPTY_VALUE: eev_q  <= cfg_data_i[ptw_pkg::SMALL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_q       <= new_d;
    saved_q     <= saved_d;
    link_addr_q <= link_addr_d;
    rst_q       <= rst_d;
    rpg_q       <= rpg_d;
    rfl_q       <= rfl_d;
    if (req_ld) begin
      type_q  <= in_type_i;
      vpn_q   <= in_va_i[ptw_pkg::VA_W-1:12];
      page_q  <= in_page_i;
      flags_q <= in_flags_i;
    end
    if (log_we) begin
      log_addr_q[nlog_q] <= cur_addr;
      log_data_q[nlog_q] <= e;
    end
    if (out_ld) begin
      ostat_q  <= rst_q;
      opage_q  <= rpg_q;
      oflags_q <= rfl_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/page_table_map_and_walk.sv =====
// Top level of the four-level page table map and walk block.
// Depends on ptw_pkg, ptw_ctrl, ptw_alu and ptw_ram.
//
//   channel   direction  ports          payload
//   s_axis    in         tdata, tuser   vaddr, phys_page, entry_flags / req_type
//   m_axis    out        tdata, tuser   found_page, found_flags / status
//   cfg       in         we, idx, data  table_base_page, table_entry_flags,
//                                       empty_entry_value
//
// After reset the root table is cleared; s_axis_tready_o stays low until that is done.
// A query makes up to four table reads, each a read state plus an evaluate
// state on the one table memory read port, then the result register load.
// A map may allocate new tables; each new one gets a 512-entry fill plus a link
// write. A rejected map undoes each logged link write before it reports.
// One request at a time; the result register holds a finished result while
// m_axis_tready_i is low and the next request is accepted meanwhile.
`default_nettype none

module page_table_map_and_walk (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [ptw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ptw_pkg::PAGE_W-1:0]         cfg_data_i,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // vaddr [47:0], phys_page [87:48], entry_flags [151:88]
  input  wire logic [ptw_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // req_type [0]
  input  wire logic                               s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // found_page [39:0], found_flags [103:40]
  output logic      [ptw_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // status [1:0]
  output logic      [ptw_pkg::STATUS_W-1:0]       m_axis_tuser_o
);

  ptw_pkg::alu_req_t           alu_req;
  ptw_pkg::alu_rsp_t           alu_rsp;
  ptw_pkg::mem_req_t           mem_req;
  logic [ptw_pkg::DATA_W-1:0]  mem_rdata;
  logic [ptw_pkg::PAGE_W-1:0]  out_page;
  logic [ptw_pkg::DATA_W-1:0]  out_flags;

  ptw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_type_i    (s_axis_tuser_i),
    .in_va_i      (s_axis_tdata_i[ptw_pkg::VA_W-1:0]),
    .in_page_i    (s_axis_tdata_i[ptw_pkg::VA_W+ptw_pkg::PAGE_W-1:ptw_pkg::VA_W]),
    .in_flags_i   (s_axis_tdata_i[ptw_pkg::IN_DATA_W-1:ptw_pkg::VA_W+ptw_pkg::PAGE_W]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_page_o   (out_page),
    .out_flags_o  (out_flags),
    .alu_req_o    (alu_req),
    .alu_rsp_i    (alu_rsp),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  ptw_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  ptw_ram #(
    .AW (ptw_pkg::ADDR_W),
    .DW (ptw_pkg::DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata_o = {out_flags, out_page};

endmodule

`default_nettype wire

// ===== design/ptw_chk.sv =====
// Port-level checker for page_table_map_and_walk, bound to the top level.
// Depends on ptw_pkg and page_table_map_and_walk_macros.svh.
`default_nettype none
`include "page_table_map_and_walk_macros.svh"

module ptw_chk (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [ptw_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic [ptw_pkg::STATUS_W-1:0]   m_axis_tuser_o
);

  // one request in flight: ready drops right after an input transfer
  `PTW_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "ready high after input transfer")

  `PTW_ASSERT_NOW(a_status_legal, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tuser_o == ptw_pkg::ST_OK || m_axis_tuser_o == ptw_pkg::ST_UNMAPPED || m_axis_tuser_o == ptw_pkg::ST_NOSPACE, "illegal status code")

  `PTW_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o != ptw_pkg::ST_OK, m_axis_tdata_o == '0, "nonzero data on failed request")

  `PTW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result dropped while stalled")

endmodule

bind page_table_map_and_walk ptw_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
